>>> rtl/core/sdf_pkg.sv
package sdf_pkg;

  localparam int NUM_CH    = 4;
  localparam int NUM_LANES = 4;
  localparam int NUM_SLOTS = 4;

  // request codes
  localparam logic [1:0] REQ_PIXEL = 2'd0;
  localparam logic [1:0] REQ_CLOSE = 2'd1;
  localparam logic [1:0] REQ_EMIT  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_HAS_ALPHA = 2'd0;
  localparam logic [1:0] CFG_OUT_WIDTH = 2'd1;

  localparam logic [10:0] OUT_WIDTH_RST = 11'd1024;

  typedef logic signed [31:0] acc_t;
  typedef logic signed [15:0] coef_t;
  typedef logic signed [47:0] prod_t;
  typedef acc_t  [NUM_CH-1:0]    chan_vec_t;
  typedef chan_vec_t [NUM_SLOTS-1:0] row_t;
  typedef prod_t [NUM_CH-1:0]    prod_vec_t;

endpackage

>>> rtl/core/sdf_in_if.sv
interface sdf_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic [31:0]       pixel;
  sdf_pkg::coef_t    coef_x0;
  sdf_pkg::coef_t    coef_x1;
  sdf_pkg::coef_t    coef_x2;
  sdf_pkg::coef_t    coef_x3;
  sdf_pkg::coef_t    coef_y0;
  sdf_pkg::coef_t    coef_y1;
  sdf_pkg::coef_t    coef_y2;
  sdf_pkg::coef_t    coef_y3;

  modport source (output valid, req_type, pixel, coef_x0, coef_x1, coef_x2, coef_x3,
                  coef_y0, coef_y1, coef_y2, coef_y3, input ready);
  modport sink   (input valid, req_type, pixel, coef_x0, coef_x1, coef_x2, coef_x3,
                  coef_y0, coef_y1, coef_y2, coef_y3, output ready);
endinterface

>>> rtl/core/sdf_out_if.sv
interface sdf_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_pixel;
  logic        row_end;

  modport source (output valid, out_pixel, row_end, input ready);
  modport sink   (input valid, out_pixel, row_end, output ready);
endinterface

>>> rtl/core/sdf_cfg_if.sv
interface sdf_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [10:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/sdf_column_mem.sv
module sdf_column_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                clk,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  output sdf_pkg::row_t       rd_data,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  sdf_pkg::row_t       wr_data
);

  sdf_pkg::row_t mem [DEPTH];
  sdf_pkg::row_t rd_data_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/core/separable_downscale_filter_core.sv
// Channel | Dir | Payload
// in_ch   | in  | req_type, pixel, coef_x0..coef_x3, coef_y0..coef_y3
// out_ch  | out | out_pixel, row_end (emit items only)
// cfg_ch  | in  | index (0 has_alpha, 1 out_width), data
//
// One item per cycle while in_ch.ready is high; an emit result passes stage A, stage B
// and the output register. Column sums live in one wide memory row per column, read at
// accept and written back from stage B; back-to-back hits on the same column are forwarded.
// After reset a clearing pass zeroes the memory, with in_ch.ready low until it ends.
// A stalled output freezes the whole pipeline and drops in_ch.ready.
module separable_downscale_filter_core #(
  parameter int MAX_OUT_WIDTH  = 1024,
  parameter int COEF_FRAC_BITS = 14
) (
  input  logic      clk,
  input  logic      rst_n,
  sdf_in_if.sink    in_ch,
  sdf_out_if.source out_ch,
  sdf_cfg_if.sink   cfg_ch
);

  localparam int AW = $clog2(MAX_OUT_WIDTH);
  localparam int F  = COEF_FRAC_BITS;

  function automatic sdf_pkg::acc_t sat32(input logic signed [49:0] v);
    if (v > 50'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -50'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic [7:0] to_byte(input sdf_pkg::acc_t v);
    logic signed [32:0] r;
    r = (33'(v) + (33'sd1 <<< (F - 1))) >>> F;
    if (v <= 32'sd0) begin
      return 8'd0;
    end else if (r > 33'sd255) begin
      return 8'd255;
    end
    return r[7:0];
  endfunction

  // configuration
  logic        has_alpha_r;
  logic [10:0] out_width_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      has_alpha_r <= 1'b0;
      out_width_r <= sdf_pkg::OUT_WIDTH_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        sdf_pkg::CFG_HAS_ALPHA: has_alpha_r <= cfg_ch.data[0];
        sdf_pkg::CFG_OUT_WIDTH: out_width_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  logic [AW-1:0] last_col;
  always_comb begin
    if (out_width_r == 11'd0) begin
      last_col = '0;
    end else if (32'(out_width_r) > 32'(MAX_OUT_WIDTH)) begin
      last_col = AW'(MAX_OUT_WIDTH - 1);
    end else begin
      last_col = AW'(32'(out_width_r) - 32'd1);
    end
  end

  // clearing pass
  logic          clearing_r;
  logic [AW-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + AW'(1);
      if (clr_addr_r == AW'(MAX_OUT_WIDTH - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // pipeline control
  logic out_valid_r;
  logic advance;
  logic accept;

  assign advance     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = advance && !clearing_r;
  assign accept      = in_ch.valid && in_ch.ready;

  // column counters, updated at accept
  logic [AW-1:0] close_col_r, emit_col_r;
  logic [1:0]    tap_r;
  logic [AW-1:0] close_col, emit_col, acc_col;
  logic          acc_last;

  assign close_col = (close_col_r >= last_col) ? last_col : close_col_r;
  assign emit_col  = (emit_col_r  >= last_col) ? last_col : emit_col_r;
  assign acc_col   = (in_ch.req_type == sdf_pkg::REQ_EMIT) ? emit_col : close_col;
  assign acc_last  = (acc_col == last_col);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      close_col_r <= '0;
      emit_col_r  <= '0;
      tap_r       <= '0;
    end else if (accept) begin
      case (in_ch.req_type)
        sdf_pkg::REQ_CLOSE: close_col_r <= acc_last ? '0 : close_col + AW'(1);
        sdf_pkg::REQ_EMIT: begin
          emit_col_r <= acc_last ? '0 : emit_col + AW'(1);
          if (acc_last) begin
            tap_r <= tap_r + 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // stage A
  logic                 a_valid_r;
  logic [1:0]           a_req_r;
  logic [31:0]          a_pixel_r;
  sdf_pkg::coef_t [3:0] a_cx_r, a_cy_r;
  logic [AW-1:0]        a_col_r;
  logic [1:0]           a_tap_r;
  logic                 a_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (advance) begin
      a_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_req_r   <= in_ch.req_type;
      a_pixel_r <= in_ch.pixel;
      a_cx_r    <= {in_ch.coef_x3, in_ch.coef_x2, in_ch.coef_x1, in_ch.coef_x0};
      a_cy_r    <= {in_ch.coef_y3, in_ch.coef_y2, in_ch.coef_y1, in_ch.coef_y0};
      a_col_r   <= acc_col;
      a_tap_r   <= tap_r;
      a_last_r  <= acc_last;
    end
  end

  // horizontal lanes
  sdf_pkg::row_t lane_r, lane_nxt;
  logic [3:0][7:0] smp;

  always_comb begin
    smp = a_pixel_r;
    if (!has_alpha_r) begin
      smp[3] = a_pixel_r[23:16];
    end
  end

  always_comb begin
    lane_nxt = lane_r;
    if (a_valid_r && a_req_r == sdf_pkg::REQ_PIXEL) begin
      for (int l = 0; l < sdf_pkg::NUM_LANES; l++) begin
        for (int c = 0; c < sdf_pkg::NUM_CH; c++) begin
          lane_nxt[l][c] = sat32(50'(lane_r[l][c])
                                 + 50'($signed({1'b0, smp[c]}) * a_cx_r[l]));
        end
      end
    end else if (a_valid_r && a_req_r == sdf_pkg::REQ_CLOSE) begin
      // shift down, clear at row end
      for (int l = 0; l < sdf_pkg::NUM_LANES - 1; l++) begin
        lane_nxt[l] = a_last_r ? '0 : lane_r[l + 1];
      end
      lane_nxt[sdf_pkg::NUM_LANES-1] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_r <= '0;
    end else if (advance) begin
      lane_r <= lane_nxt;
    end
  end

  // stage B
  logic                              b_valid_r;
  logic [1:0]                        b_req_r;
  logic [AW-1:0]                     b_col_r;
  logic [1:0]                        b_tap_r;
  logic                              b_last_r;
  sdf_pkg::prod_vec_t [3:0]          b_prod_r;
  sdf_pkg::row_t                     b_rd_r;
  sdf_pkg::row_t                     rd_row;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (advance) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      b_req_r  <= a_req_r;
      b_col_r  <= a_col_r;
      b_tap_r  <= a_tap_r;
      b_last_r <= a_last_r;
      b_rd_r   <= rd_row;
      for (int m = 0; m < sdf_pkg::NUM_SLOTS; m++) begin
        for (int c = 0; c < sdf_pkg::NUM_CH; c++) begin
          b_prod_r[m][c] <= lane_r[0][c] * a_cy_r[m];
        end
      end
    end
  end

  // write history for forwarding
  logic          wr1_v_r, wr2_v_r;
  logic [AW-1:0] wr1_addr_r, wr2_addr_r;
  sdf_pkg::row_t wr1_data_r, wr2_data_r;

  sdf_pkg::row_t base_row, new_row;
  logic          b_write;
  logic [3:0][7:0] bytes;
  logic [7:0]    mx;

  assign b_write = b_valid_r && (b_req_r == sdf_pkg::REQ_CLOSE || b_req_r == sdf_pkg::REQ_EMIT);

  always_comb begin
    if (wr1_v_r && wr1_addr_r == b_col_r) begin
      base_row = wr1_data_r;
    end else if (wr2_v_r && wr2_addr_r == b_col_r) begin
      base_row = wr2_data_r;
    end else begin
      base_row = b_rd_r;
    end
  end

  always_comb begin
    logic [1:0]               s;
    logic signed [48:0]       rnd;
    s       = '0;
    rnd     = '0;
    new_row = base_row;
    for (int c = 0; c < sdf_pkg::NUM_CH; c++) begin
      bytes[c] = to_byte(base_row[b_tap_r][c]);
    end
    mx = (bytes[1] > bytes[0]) ? bytes[1] : bytes[0];
    mx = (bytes[2] > mx) ? bytes[2] : mx;
    if (!has_alpha_r) begin
      bytes[3] = 8'd255;
    end else if (mx > bytes[3]) begin
      bytes[3] = mx;
    end
    if (b_req_r == sdf_pkg::REQ_CLOSE) begin
      for (int m = 0; m < sdf_pkg::NUM_SLOTS; m++) begin
        s = b_tap_r + 2'(m);
        for (int c = 0; c < sdf_pkg::NUM_CH; c++) begin
          rnd = (49'(b_prod_r[m][c]) + (49'sd1 <<< (F - 1))) >>> F;
          new_row[s][c] = sat32(50'(base_row[s][c]) + 50'(rnd));
        end
      end
    end else begin
      new_row[b_tap_r] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr1_v_r <= 1'b0;
      wr2_v_r <= 1'b0;
    end else if (advance) begin
      wr1_v_r <= b_write;
      wr2_v_r <= wr1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      wr1_addr_r <= b_col_r;
      wr1_data_r <= new_row;
      wr2_addr_r <= wr1_addr_r;
      wr2_data_r <= wr1_data_r;
    end
  end

  sdf_column_mem #(
    .DEPTH (MAX_OUT_WIDTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (acc_col),
    .rd_data (rd_row),
    .wr_en   (clearing_r || (advance && b_write)),
    .wr_addr (clearing_r ? clr_addr_r : b_col_r),
    .wr_data (clearing_r ? '0 : new_row)
  );

  // output register
  logic [31:0] out_pixel_r;
  logic        row_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= b_valid_r && b_req_r == sdf_pkg::REQ_EMIT;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_pixel_r <= bytes;
      row_end_r   <= b_last_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_pixel = out_pixel_r;
  assign out_ch.row_end   = row_end_r;

endmodule

>>> sim/sdf_scoreboard.sv
module sdf_scoreboard (
  input  logic  clk,
  input  logic  rst_n,
  sdf_in_if     in_ch,
  sdf_out_if    out_ch,
  sdf_cfg_if    cfg_ch,
  output int    errors,
  output int    outstanding,
  output int    pixels_seen
);

  localparam int MAXW = 1024;

  typedef struct packed {
    logic [31:0] out_pixel;
    logic        row_end;
  } dsp_px_t;

  dsp_px_t        pending_px[$];
  logic           alpha_en;
  logic [10:0]    width_reg;
  sdf_pkg::acc_t  lanes[sdf_pkg::NUM_LANES][sdf_pkg::NUM_CH];
  sdf_pkg::acc_t  colsum[MAXW][sdf_pkg::NUM_SLOTS][sdf_pkg::NUM_CH];
  logic [1:0]     tap;
  int             close_col;
  int             emit_col;

  function automatic sdf_pkg::acc_t sat32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return sdf_pkg::acc_t'(v);
  endfunction

  function automatic int eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAXW) return MAXW;
    return int'(width_reg);
  endfunction

  function automatic logic [7:0] sum_to_byte(sdf_pkg::acc_t v);
    longint r;
    if (v <= 0) return 8'd0;
    r = (longint'(v) + 8192) >>> 14;
    return r > 255 ? 8'd255 : r[7:0];
  endfunction

  task automatic predict_item();
    longint     smp[sdf_pkg::NUM_CH];
    longint     cx[sdf_pkg::NUM_LANES];
    longint     cy[sdf_pkg::NUM_SLOTS];
    int         w;
    int         col;
    logic [1:0] slot;
    logic [7:0] b[sdf_pkg::NUM_CH];
    logic [7:0] mx;
    dsp_px_t    e;
    w = eff_width();
    cx[0] = in_ch.coef_x0; cx[1] = in_ch.coef_x1;
    cx[2] = in_ch.coef_x2; cx[3] = in_ch.coef_x3;
    cy[0] = in_ch.coef_y0; cy[1] = in_ch.coef_y1;
    cy[2] = in_ch.coef_y2; cy[3] = in_ch.coef_y3;
    case (in_ch.req_type)
      sdf_pkg::REQ_PIXEL: begin
        for (int c = 0; c < sdf_pkg::NUM_CH; c++) smp[c] = in_ch.pixel[8*c +: 8];
        if (!alpha_en) smp[3] = smp[2];
        for (int l = 0; l < sdf_pkg::NUM_LANES; l++)
          for (int c = 0; c < sdf_pkg::NUM_CH; c++)
            lanes[l][c] = sat32(longint'(lanes[l][c]) + smp[c] * cx[l]);
      end
      sdf_pkg::REQ_CLOSE: begin
        col = close_col >= w - 1 ? w - 1 : close_col;
        for (int m = 0; m < sdf_pkg::NUM_SLOTS; m++) begin
          slot = tap + m[1:0];
          for (int c = 0; c < sdf_pkg::NUM_CH; c++)
            colsum[col][slot][c] = sat32(longint'(colsum[col][slot][c]) +
                                         ((longint'(lanes[0][c]) * cy[m] + 8192) >>> 14));
        end
        for (int l = 0; l < sdf_pkg::NUM_LANES - 1; l++) lanes[l] = lanes[l+1];
        for (int c = 0; c < sdf_pkg::NUM_CH; c++) lanes[3][c] = '0;
        if (col == w - 1) begin
          for (int l = 0; l < sdf_pkg::NUM_LANES; l++)
            for (int c = 0; c < sdf_pkg::NUM_CH; c++) lanes[l][c] = '0;
          close_col = 0;
        end else begin
          close_col = col + 1;
        end
      end
      sdf_pkg::REQ_EMIT: begin
        col = emit_col >= w - 1 ? w - 1 : emit_col;
        for (int c = 0; c < sdf_pkg::NUM_CH; c++) begin
          b[c] = sum_to_byte(colsum[col][tap][c]);
          colsum[col][tap][c] = '0;
        end
        if (alpha_en) begin
          mx = b[0];
          if (b[1] > mx) mx = b[1];
          if (b[2] > mx) mx = b[2];
          if (mx > b[3]) b[3] = mx;
        end else begin
          b[3] = 8'd255;
        end
        e.out_pixel = {b[3], b[2], b[1], b[0]};
        e.row_end   = (col == w - 1);
        pending_px.push_back(e);
        if (e.row_end) begin
          emit_col = 0;
          tap = tap + 2'd1;
        end else begin
          emit_col = col + 1;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    dsp_px_t e;
    if (!rst_n) begin
      alpha_en  = 1'b0;
      width_reg = sdf_pkg::OUT_WIDTH_RST;
      for (int l = 0; l < sdf_pkg::NUM_LANES; l++)
        for (int c = 0; c < sdf_pkg::NUM_CH; c++) lanes[l][c] = '0;
      for (int k = 0; k < MAXW; k++)
        for (int s = 0; s < sdf_pkg::NUM_SLOTS; s++)
          for (int c = 0; c < sdf_pkg::NUM_CH; c++) colsum[k][s][c] = '0;
      tap = '0;
      close_col = 0;
      emit_col = 0;
      errors = 0;
      pixels_seen = 0;
      pending_px.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == sdf_pkg::CFG_HAS_ALPHA) alpha_en = cfg_ch.data[0];
        else if (cfg_ch.index == sdf_pkg::CFG_OUT_WIDTH) width_reg = cfg_ch.data;
      end
      if (out_ch.valid && out_ch.ready) begin
        pixels_seen++;
        if (pending_px.size() == 0) begin
          $error("unexpected output pixel %h", out_ch.out_pixel);
          errors++;
        end else begin
          e = pending_px.pop_front();
          if (out_ch.out_pixel !== e.out_pixel) begin
            $error("out_pixel: expected %h, got %h", e.out_pixel, out_ch.out_pixel);
            errors++;
          end
          if (out_ch.row_end !== e.row_end) begin
            $error("row_end: expected %b, got %b", e.row_end, out_ch.row_end);
            errors++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) predict_item();
    end
    outstanding = pending_px.size();
  end

endmodule

>>> sim/tb_separable_downscale_filter_core.sv
module tb_separable_downscale_filter_core;

  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic quiet = 1'b0;
  int   errors, outstanding, pixels_seen;
  int   items_sent = 0;
  int   cycles = 0;
  int   stall_left = 0;
  int   cur_width = 1024;

  sdf_in_if  in_ch();
  sdf_out_if out_ch();
  sdf_cfg_if cfg_ch();

  separable_downscale_filter_core u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  sdf_scoreboard u_sb (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
    .errors(errors), .outstanding(outstanding), .pixels_seen(pixels_seen)
  );

  always #4 clk = ~clk;

  // receiver stalls in random bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (quiet) begin
      out_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left   <= $urandom_range(0, 9);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic sdf_pkg::coef_t pick_coef();
    case ($urandom_range(0, 11))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return sdf_pkg::coef_t'($urandom);
      default: return sdf_pkg::coef_t'(int'($urandom_range(0, 32767)) - 16384);
    endcase
  endfunction

  task automatic send(logic [1:0] req, logic [31:0] px,
                      sdf_pkg::coef_t x0, sdf_pkg::coef_t x1,
                      sdf_pkg::coef_t x2, sdf_pkg::coef_t x3,
                      sdf_pkg::coef_t y0, sdf_pkg::coef_t y1,
                      sdf_pkg::coef_t y2, sdf_pkg::coef_t y3);
    in_ch.valid   <= 1'b1;
    in_ch.req_type <= req;
    in_ch.pixel   <= px;
    in_ch.coef_x0 <= x0; in_ch.coef_x1 <= x1; in_ch.coef_x2 <= x2; in_ch.coef_x3 <= x3;
    in_ch.coef_y0 <= y0; in_ch.coef_y1 <= y1; in_ch.coef_y2 <= y2; in_ch.coef_y3 <= y3;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic send_random(logic [1:0] req);
    send(req, $urandom, pick_coef(), pick_coef(), pick_coef(), pick_coef(),
         pick_coef(), pick_coef(), pick_coef(), pick_coef());
  endtask

  // hold the input, drain every result, let the pipeline settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [10:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(logic alpha, logic [10:0] w);
    drain();
    write_reg(sdf_pkg::CFG_HAS_ALPHA, {10'd0, alpha});
    write_reg(sdf_pkg::CFG_OUT_WIDTH, w);
    cur_width = (w == 0) ? 1 : (w > 1024) ? 1024 : int'(w);
  endtask

  // one output row: pixels and a close per column, then emits for each column
  task automatic run_row();
    int cols;
    cols = cur_width > 6 ? $urandom_range(1, 6) : cur_width;
    for (int c = 0; c < cols; c++) begin
      repeat ($urandom_range(1, 3)) send_random(sdf_pkg::REQ_PIXEL);
      send_random(sdf_pkg::REQ_CLOSE);
    end
    for (int c = 0; c < cols; c++) send_random(sdf_pkg::REQ_EMIT);
  endtask

  task automatic run_phase(int target, bool_pause);
    int stop_at;
    stop_at = items_sent + target;
    while (items_sent < stop_at) begin
      if (items_sent > 1250) quiet = 1'b1;
      if (bool_pause != 0 && items_sent > stop_at - target / 2) begin
        drain();
        bool_pause = 0;
      end
      if ($urandom_range(0, 6) == 0) send_random(2'($urandom_range(0, 3)));
      else run_row();
    end
  endtask

  initial begin
    in_ch.valid = 1'b0; in_ch.req_type = sdf_pkg::REQ_PIXEL; in_ch.pixel = '0;
    in_ch.coef_x0 = '0; in_ch.coef_x1 = '0; in_ch.coef_x2 = '0; in_ch.coef_x3 = '0;
    in_ch.coef_y0 = '0; in_ch.coef_y1 = '0; in_ch.coef_y2 = '0; in_ch.coef_y3 = '0;
    cfg_ch.valid = 1'b0; cfg_ch.index = sdf_pkg::CFG_HAS_ALPHA; cfg_ch.data = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    configure(1'b0, 11'd1);
    // directed: field extremes, every request, saturation, row ends
    send(sdf_pkg::REQ_PIXEL, 32'h0000_0000, 16'sh7fff, 16'sh8000, 16'sh0000, 16'sh4000,
         16'sh0, 16'sh0, 16'sh0, 16'sh0);
    send(sdf_pkg::REQ_PIXEL, 32'hffff_ffff, 16'sh7fff, 16'sh8000, 16'shffff, 16'sh4000,
         16'sh0, 16'sh0, 16'sh0, 16'sh0);
    send(sdf_pkg::REQ_CLOSE, 32'h0, 16'sh0, 16'sh0, 16'sh0, 16'sh0,
         16'sh4000, 16'sh7fff, 16'sh8000, 16'shffff);
    send(sdf_pkg::REQ_EMIT, 32'h0, '0, '0, '0, '0, '0, '0, '0, '0);
    repeat (6) send(sdf_pkg::REQ_PIXEL, 32'hffff_ffff, 16'sh7fff, 16'sh7fff,
                    16'sh8000, 16'sh8000, '0, '0, '0, '0);
    send(sdf_pkg::REQ_CLOSE, 32'h0, '0, '0, '0, '0,
         16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send(sdf_pkg::REQ_CLOSE, 32'h0, '0, '0, '0, '0,
         16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send(sdf_pkg::REQ_EMIT, 32'h0, '0, '0, '0, '0, '0, '0, '0, '0);
    send(2'd3, 32'hffff_ffff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
         16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    repeat (4) send(sdf_pkg::REQ_EMIT, 32'h0, '0, '0, '0, '0, '0, '0, '0, '0);
    configure(1'b1, 11'd1);
    send(sdf_pkg::REQ_PIXEL, 32'h10ff_8040, 16'sh4000, 16'sh2000, 16'sh1000, 16'sh0800,
         '0, '0, '0, '0);
    send(sdf_pkg::REQ_CLOSE, 32'h0, '0, '0, '0, '0,
         16'sh4000, 16'sh4000, 16'sh4000, 16'sh4000);
    repeat (4) send(sdf_pkg::REQ_EMIT, 32'h0, '0, '0, '0, '0, '0, '0, '0, '0);

    configure(1'b1, 11'd4);    run_phase(170, 1);
    configure(1'b0, 11'd0);    run_phase(170, 0);
    configure(1'b1, 11'd3);    run_phase(170, 0);
    configure(1'b0, 11'd2047); run_phase(120, 0);
    configure(1'b1, 11'd7);    run_phase(170, 0);
    configure(1'b1, 11'd1025); run_phase(100, 0);
    configure(1'b0, 11'd2);    run_phase(170, 0);
    configure(1'b1, 11'd1);    run_phase(170, 0);
    configure(1'b0, 11'd5);    run_phase(150, 0);

    in_ch.valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("sent %0d items over ten register settings, checked %0d output pixels",
             items_sent, pixels_seen);
    $display("widths 0 to 2047, alpha on and off, saturating weights and request code 3");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
